@@ rtl/lfrr_pkg.sv @@
// ----------------------------------------------------------------------------
// lfrr_pkg
// Shared constants, codes and types of the length-framed response receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package lfrr_pkg;

    // frame geometry
    localparam int HEADER_BYTES    = 6;
    localparam int MAX_FRAME_BYTES = 256;
    localparam int PAYLOAD_DEPTH   = MAX_FRAME_BYTES - HEADER_BYTES;
    localparam int LEN_HI_POS      = 4;
    localparam int LEN_LO_POS      = 5;
    localparam int TYPE_POS        = 1;
    localparam int ID_POS          = 2;

    // widths
    localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int HDR_W   = $clog2(HEADER_BYTES);
    localparam int LEN_W   = 16;
    localparam int SUM_W   = LEN_W + 1;
    localparam int IDX_W   = (POS_W > 9) ? POS_W : 9;
    localparam int LANES   = 4;
    localparam int PAY_ROWS = (PAYLOAD_DEPTH + LANES - 1) / LANES;
    localparam int ROW_W   = (PAY_ROWS > 1) ? $clog2(PAY_ROWS) : 1;
    localparam int BANK_DEPTH = 1 << ROW_W;

    // nack signature
    localparam logic [7:0] NACK_TYPE = 8'h00;
    localparam logic [7:0] NACK_ID   = 8'h02;

    // register reset values
    localparam logic [7:0]       START_BYTE_RST = 8'd254;
    localparam logic [7:0]       END_BYTE_RST   = 8'd253;
    localparam logic [LEN_W-1:0] TIMEOUT_RST    = 16'd200;

    // commands
    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    // read sizes
    localparam logic [1:0] RD_SZ_1B = 2'd0;
    localparam logic [1:0] RD_SZ_2B = 2'd1;
    localparam logic [1:0] RD_SZ_4B = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ACK      = 3'd0;
    localparam logic [2:0] ST_NACK     = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_READ_OK  = 3'd4;
    localparam logic [2:0] ST_READ_BAD = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_START   = 2'd0;
    localparam logic [1:0] CFG_END     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    // payload store write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] off;
        logic [7:0]       data;
    } t_pay_wr;

    // payload store read request
    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic [1:0] size;
    } t_pay_rd;

endpackage

`default_nettype wire

@@ rtl/length_framed_response_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// length_framed_response_receiver_unit
// Receives one length-framed response from a serial byte stream.
// A result is registered in the result stage, then in the output
// register. Throughput: one item per cycle while the output is not
// stalled; the payload banks take one write or one read per item and
// the result stage holds the bank read data.
// Reset: synchronous active low; idle, registers at default values, no
// clearing pass, payload and header contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module length_framed_response_receiver_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_read_index,
    input  wire logic [1:0]  i_read_size,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [2:0]  o_status,
    output logic      [7:0]  o_frame_type,
    output logic      [7:0]  o_frame_id,
    output logic      [15:0] o_payload_length,
    output logic      [31:0] o_read_value,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int HB = lfrr_pkg::HEADER_BYTES;

    // configuration registers
    logic [7:0]                 r_start_byte;
    logic [7:0]                 r_end_byte;
    logic [lfrr_pkg::LEN_W-1:0] r_timeout;

    // receive state
    logic                       r_receiving, n_receiving;
    logic [lfrr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [lfrr_pkg::LEN_W-1:0] r_len, n_len;
    logic [lfrr_pkg::LEN_W-1:0] r_ticks, n_ticks;
    logic [7:0]                 r_header [HB];

    // result stage holding the bank read
    logic                       r_s1_valid;
    logic [2:0]                 r_s1_status;
    logic [7:0]                 r_s1_type;
    logic [7:0]                 r_s1_id;
    logic [lfrr_pkg::LEN_W-1:0] r_s1_len;
    logic                       r_s1_rd_ok;

    // output register
    logic                       r_out_valid;
    logic [2:0]                 r_out_status;
    logic [7:0]                 r_out_type;
    logic [7:0]                 r_out_id;
    logic [lfrr_pkg::LEN_W-1:0] r_out_len;
    logic [31:0]                r_out_value;

    // stage-0 decode
    logic                       w_in_fire;
    logic                       w_s1_move;
    logic                       w_res_valid;
    logic [2:0]                 w_res_status;
    logic                       w_res_fields;
    logic                       w_res_rd_ok;
    logic                       w_hdr_we;
    logic [lfrr_pkg::POS_W-1:0] w_pos;
    logic [lfrr_pkg::POS_W-1:0] w_pos_inc;
    logic [lfrr_pkg::POS_W-1:0] w_off;
    logic [lfrr_pkg::SUM_W-1:0] w_frame_end;
    logic [lfrr_pkg::SUM_W-1:0] w_rd_last;
    logic [1:0]                 w_nm1;
    lfrr_pkg::t_pay_wr          w_wr;
    lfrr_pkg::t_pay_rd          w_rd;
    logic [31:0]                w_pay_value;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign w_s1_move   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_s1_move;
    assign w_in_fire   = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= lfrr_pkg::START_BYTE_RST;
            r_end_byte   <= lfrr_pkg::END_BYTE_RST;
            r_timeout    <= lfrr_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lfrr_pkg::CFG_START:   r_start_byte <= i_cfg_data[7:0];
                lfrr_pkg::CFG_END:     r_end_byte   <= i_cfg_data[7:0];
                lfrr_pkg::CFG_TIMEOUT: r_timeout    <= i_cfg_data;
                default:               ;
            endcase
        end
    end

    // byte position arithmetic
    assign w_pos       = (i_data_byte == r_start_byte) ? '0 : r_pos;
    assign w_pos_inc   = w_pos + 1'b1;
    assign w_off       = w_pos - lfrr_pkg::POS_W'(HB);
    assign w_frame_end = lfrr_pkg::SUM_W'(HB) + lfrr_pkg::SUM_W'(r_len);
    assign w_rd_last   = lfrr_pkg::SUM_W'(i_read_index) + lfrr_pkg::SUM_W'(w_nm1);

    // last byte offset of a read
    always_comb begin
        case (i_read_size)
            lfrr_pkg::RD_SZ_1B: w_nm1 = 2'd0;
            lfrr_pkg::RD_SZ_2B: w_nm1 = 2'd1;
            default:            w_nm1 = 2'd3;
        endcase
    end

    // command decode and next state
    always_comb begin
        n_receiving  = r_receiving;
        n_pos        = r_pos;
        n_len        = r_len;
        n_ticks      = r_ticks;
        w_res_valid  = 1'b0;
        w_res_status = lfrr_pkg::ST_ACK;
        w_res_fields = 1'b0;
        w_res_rd_ok  = 1'b0;
        w_hdr_we     = 1'b0;
        w_wr.en      = 1'b0;
        w_wr.off     = lfrr_pkg::IDX_W'(w_off);
        w_wr.data    = i_data_byte;
        w_rd.en      = 1'b0;
        w_rd.index   = i_read_index;
        w_rd.size    = i_read_size;
        if (w_in_fire) begin
            case (i_command)
                lfrr_pkg::CMD_ARM: begin
                    n_receiving = 1'b1;
                    n_pos       = '0;
                    n_len       = '0;
                    n_ticks     = r_timeout;
                end
                lfrr_pkg::CMD_BYTE: begin
                    if (r_receiving) begin
                        // store into header or payload
                        if (w_pos < lfrr_pkg::POS_W'(HB)) begin
                            w_hdr_we = 1'b1;
                            if (w_pos == lfrr_pkg::POS_W'(lfrr_pkg::LEN_LO_POS)) begin
                                n_len = {r_header[lfrr_pkg::LEN_HI_POS], i_data_byte};
                            end
                        end else if (lfrr_pkg::SUM_W'(w_off) < lfrr_pkg::SUM_W'(r_len) &&
                                     w_off < lfrr_pkg::POS_W'(lfrr_pkg::PAYLOAD_DEPTH)) begin
                            w_wr.en = 1'b1;
                        end
                        // frame close, else advance and check size
                        if (i_data_byte == r_end_byte &&
                            lfrr_pkg::SUM_W'(w_pos) == w_frame_end) begin
                            n_receiving  = 1'b0;
                            w_res_valid  = 1'b1;
                            w_res_fields = 1'b1;
                            w_res_status =
                                (r_header[lfrr_pkg::TYPE_POS] == lfrr_pkg::NACK_TYPE &&
                                 r_header[lfrr_pkg::ID_POS] == lfrr_pkg::NACK_ID)
                                ? lfrr_pkg::ST_NACK : lfrr_pkg::ST_ACK;
                        end else begin
                            n_pos = w_pos_inc;
                            if (w_pos_inc >= lfrr_pkg::POS_W'(lfrr_pkg::MAX_FRAME_BYTES)) begin
                                n_receiving  = 1'b0;
                                w_res_valid  = 1'b1;
                                w_res_status = lfrr_pkg::ST_OVERFLOW;
                            end
                        end
                    end
                end
                lfrr_pkg::CMD_TICK: begin
                    if (r_receiving) begin
                        if (r_ticks <= lfrr_pkg::LEN_W'(1)) begin
                            n_ticks      = '0;
                            n_receiving  = 1'b0;
                            w_res_valid  = 1'b1;
                            w_res_status = lfrr_pkg::ST_TIMEOUT;
                        end else begin
                            n_ticks = r_ticks - 1'b1;
                        end
                    end
                end
                default: begin
                    // payload read, always answered
                    w_rd.en      = 1'b1;
                    w_res_valid  = 1'b1;
                    w_res_fields = 1'b1;
                    if (i_read_size != lfrr_pkg::RD_SZ_1B &&
                        i_read_size != lfrr_pkg::RD_SZ_2B &&
                        i_read_size != lfrr_pkg::RD_SZ_4B) begin
                        w_res_status = lfrr_pkg::ST_READ_BAD;
                    end else if (lfrr_pkg::SUM_W'(r_len) > w_rd_last) begin
                        w_res_status = lfrr_pkg::ST_READ_OK;
                        w_res_rd_ok  = 1'b1;
                    end else begin
                        w_res_status = lfrr_pkg::ST_READ_BAD;
                    end
                end
            endcase
        end
    end

    // receive state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_pos       <= '0;
            r_len       <= '0;
            r_ticks     <= '0;
        end else begin
            r_receiving <= n_receiving;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_ticks     <= n_ticks;
        end
    end

    // header bytes
    always_ff @(posedge i_clk) begin
        if (w_hdr_we) begin
            r_header[w_pos[lfrr_pkg::HDR_W-1:0]] <= i_data_byte;
        end
    end

    // payload banks
    lfrr_payload_store u_payload (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_value (w_pay_value)
    );

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= w_in_fire && w_res_valid;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_status <= w_res_status;
            r_s1_type   <= w_res_fields ? r_header[lfrr_pkg::TYPE_POS] : 8'h00;
            r_s1_id     <= w_res_fields ? r_header[lfrr_pkg::ID_POS] : 8'h00;
            r_s1_len    <= w_res_fields ? r_len : '0;
            r_s1_rd_ok  <= w_res_rd_ok;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_status <= r_s1_status;
            r_out_type   <= r_s1_type;
            r_out_id     <= r_s1_id;
            r_out_len    <= r_s1_len;
            r_out_value  <= r_s1_rd_ok ? w_pay_value : 32'h0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_frame_type     = r_out_type;
    assign o_frame_id       = r_out_id;
    assign o_payload_length = r_out_len;
    assign o_read_value     = r_out_value;

    // payload is only written during a receive
    a_wr_receiving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> r_receiving)
        else $error("payload write while idle");

    // a stalled result stage keeps its transfer
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |=> (r_s1_valid && $stable(r_s1_status)))
        else $error("result stage lost a pending transfer");

    // every accepted read produces a result
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_command == lfrr_pkg::CMD_READ) |=> r_s1_valid)
        else $error("read without result");

    // bank read data is never replaced while it is still needed
    a_no_read_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |-> !w_rd.en)
        else $error("bank read while result stage stalled");

    // position never passes the frame limit
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= lfrr_pkg::POS_W'(lfrr_pkg::MAX_FRAME_BYTES))
        else $error("byte position out of range");

endmodule

`default_nettype wire

@@ rtl/lfrr_ram.sv @@
// ----------------------------------------------------------------------------
// lfrr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/lfrr_payload_store.sv @@
// ----------------------------------------------------------------------------
// lfrr_payload_store
// Payload byte store in four interleaved banks, so that a 1, 2 or 4 byte
// big-endian value is read at any byte offset in a single access.
// ----------------------------------------------------------------------------
`default_nettype none

module lfrr_payload_store (
    input  wire logic             i_clk,
    input  wire lfrr_pkg::t_pay_wr i_wr,
    input  wire lfrr_pkg::t_pay_rd i_rd,
    output logic      [31:0]      o_value
);

    logic [7:0]                 w_q     [lfrr_pkg::LANES];
    logic [lfrr_pkg::IDX_W-1:0] r_base;
    logic [1:0]                 r_size;
    logic [7:0]                 w_byte  [lfrr_pkg::LANES];

    // one bank per low offset bit pair
    for (genvar j = 0; j < lfrr_pkg::LANES; j++) begin : g_bank
        logic [1:0]                 w_k;
        logic [lfrr_pkg::IDX_W-1:0] w_addr;

        assign w_k    = 2'(j) - i_rd.index[1:0];
        assign w_addr = lfrr_pkg::IDX_W'(i_rd.index) + lfrr_pkg::IDX_W'(w_k);

        lfrr_ram #(
            .WIDTH (8),
            .DEPTH (lfrr_pkg::BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (i_wr.en && (i_wr.off[1:0] == 2'(j))),
            .i_waddr (i_wr.off[lfrr_pkg::ROW_W+1:2]),
            .i_wdata (i_wr.data),
            .i_re    (i_rd.en),
            .i_raddr (w_addr[lfrr_pkg::ROW_W+1:2]),
            .o_rdata (w_q[j])
        );
    end

    // remember where the read started, aligned with the bank data
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_base <= lfrr_pkg::IDX_W'(i_rd.index);
            r_size <= i_rd.size;
        end
    end

    // pick each byte from its bank, bytes beyond the store read as zero
    always_comb begin
        logic [lfrr_pkg::IDX_W-1:0] v_idx;
        for (int k = 0; k < lfrr_pkg::LANES; k++) begin
            v_idx     = r_base + lfrr_pkg::IDX_W'(k);
            w_byte[k] = (v_idx < lfrr_pkg::IDX_W'(lfrr_pkg::PAYLOAD_DEPTH))
                        ? w_q[v_idx[1:0]] : 8'h00;
        end
    end

    // big-endian assembly
    always_comb begin
        case (r_size)
            lfrr_pkg::RD_SZ_1B: o_value = {24'h0, w_byte[0]};
            lfrr_pkg::RD_SZ_2B: o_value = {16'h0, w_byte[0], w_byte[1]};
            default:            o_value = {w_byte[0], w_byte[1], w_byte[2], w_byte[3]};
        endcase
    end

endmodule

`default_nettype wire
